### src/mgs_pkg.sv
// ============================================================================
// mgs_pkg
// Shared types, constants and the glyph pattern table of the marching
// squares glyph generator.
// ============================================================================
package mgs_pkg;

  // default geometry limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // fixed field widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CELL_W   = 10;
  localparam int unsigned IWIDTH_W = 11;
  localparam int unsigned CODE_W   = 4;
  localparam int unsigned GLYPH_N  = 9;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL    = CFG_IDX_W'(3);

  // register reset values
  localparam logic [IWIDTH_W-1:0] RST_IMAGE_WIDTH = IWIDTH_W'(1024);
  localparam logic [PIX_W-1:0]    RST_LEVEL       = PIX_W'(128);
  localparam logic [PIX_W-1:0]    RST_OFF_LEVEL   = PIX_W'(0);
  localparam logic [PIX_W-1:0]    RST_ON_LEVEL    = PIX_W'(255);

  // result bus packing
  localparam int unsigned OUT_BITS   = 2 * CELL_W + GLYPH_N * PIX_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // contour positions per cell case, bit (3*row + col)
  localparam logic [GLYPH_N-1:0] GLYPH_MASK [16] = '{
    9'h000, 9'h0C8, 9'h1A0, 9'h038, 9'h026, 9'h0EE, 9'h092, 9'h00B,
    9'h00B, 9'h092, 9'h1AB, 9'h026, 9'h038, 9'h1A0, 9'h0C8, 9'h000
  };

  // one classified cell travelling from front to back
  typedef struct packed {
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic [CODE_W-1:0] code;
  } mgs_cell_t;

endpackage

### src/mgs_front.sv
// ============================================================================
// mgs_front
// Pixel intake: position counters, previous-row line store, and 2x2 corner
// thresholding into a 4-bit cell case.
// ============================================================================
module mgs_front #(
  parameter int unsigned MAX_WIDTH  = mgs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mgs_pkg::PIX_W-1:0]       in_pixel,
  input  logic                            in_start,
  input  logic [mgs_pkg::IWIDTH_W-1:0]    image_width,
  input  logic [mgs_pkg::PIX_W-1:0]       level,
  output logic                            q_valid,
  input  logic                            q_ready,
  output mgs_pkg::mgs_cell_t              q_data
);
  import mgs_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned AWN = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW  = (AWN > IWIDTH_W) ? AWN : IWIDTH_W;
  localparam int unsigned REW = (RW > CELL_W) ? RW : CELL_W;
  localparam int unsigned CEW = (CW > CELL_W) ? CW : CELL_W;

  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic [CW-1:0]    col_eff;
  logic [RW-1:0]    row_eff;
  logic             drop;
  logic             load;
  logic             wrap;
  logic [AW-1:0]    iw_ext;
  logic [AW-1:0]    act_w;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_r;

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic             s1_emit_r;
  logic [PIX_W-1:0] s1_px_r;
  logic [RW-1:0]    s1_row_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_adv;

  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] ul_r;
  logic [REW-1:0]   row_ext;
  logic [CEW-1:0]   col_ext;

  // position of this pixel and clamped row width
  always_comb begin
    col_eff = in_start ? '0 : col_r;
    row_eff = in_start ? '0 : row_r;
    drop    = (row_eff >= RW'(MAX_HEIGHT));
    iw_ext  = AW'(image_width);
    if (iw_ext < AW'(2)) begin
      act_w = AW'(2);
    end else if (iw_ext > AW'(MAX_WIDTH)) begin
      act_w = AW'(MAX_WIDTH);
    end else begin
      act_w = iw_ext;
    end
    wrap = ((AW'(col_eff) + AW'(1)) >= act_w);
  end

  // stage 1 moves on when the queue can take its cell, or it has none
  assign s1_adv   = s1_valid_r && (!s1_emit_r || q_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign load     = in_valid && in_ready && !drop;

  // raster counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (load) begin
      if (wrap) begin
        col_r <= '0;
        row_r <= row_eff + RW'(1);
      end else begin
        col_r <= col_eff + CW'(1);
        row_r <= row_eff;
      end
    end
  end

  // line store, read-first on the shared address
  always_ff @(posedge clk) begin
    if (load) begin
      up_r              <= line_mem[col_eff];
      line_mem[col_eff] <= in_pixel;
    end
  end

  // stage 1 valid
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (load) begin
      s1_px_r   <= in_pixel;
      s1_row_r  <= row_eff;
      s1_col_r  <= col_eff;
      s1_emit_r <= (row_eff != '0) && (col_eff != '0);
    end
  end

  // left and upper-left neighbors follow the retired pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (s1_adv) begin
      left_r <= s1_px_r;
      ul_r   <= up_r;
    end
  end

  // corner thresholds and cell coordinates
  always_comb begin
    row_ext     = REW'(s1_row_r) - REW'(1);
    col_ext     = CEW'(s1_col_r) - CEW'(1);
    q_valid     = s1_valid_r && s1_emit_r;
    q_data.row  = row_ext[CELL_W-1:0];
    q_data.col  = col_ext[CELL_W-1:0];
    q_data.code = {(ul_r >= level), (up_r >= level), (s1_px_r >= level), (left_r >= level)};
  end

endmodule

### src/mgs_queue.sv
// ============================================================================
// mgs_queue
// Two-entry queue of classified cells between intake and glyph output.
// ============================================================================
module mgs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  mgs_pkg::mgs_cell_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output mgs_pkg::mgs_cell_t rd_data
);
  import mgs_pkg::*;

  mgs_cell_t  slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       push;
  logic       pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### src/mgs_back.sv
// ============================================================================
// mgs_back
// Glyph expansion: looks up the contour pattern of a cell case and drives
// the registered result stream.
// ============================================================================
module mgs_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_ready,
  input  mgs_pkg::mgs_cell_t                   q_data,
  input  logic [mgs_pkg::PIX_W-1:0]            off_level,
  input  logic [mgs_pkg::PIX_W-1:0]            on_level,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mgs_pkg::OUT_DATA_W-1:0]       out_tdata
);
  import mgs_pkg::*;

  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic                           pop;
  logic [GLYPH_N-1:0]             mask;
  logic [GLYPH_N*PIX_W-1:0]       glyph;
  logic [CELL_W-1:0]              row_r;
  logic [CELL_W-1:0]              col_r;
  logic [GLYPH_N*PIX_W-1:0]       glyph_r;

  assign q_ready = !out_valid_r || out_tready;
  assign pop     = q_valid && q_ready;

  // pattern lookup and level selection
  always_comb begin
    mask = GLYPH_MASK[q_data.code];
    for (int k = 0; k < GLYPH_N; k++) begin
      glyph[k*PIX_W +: PIX_W] = mask[k] ? on_level : off_level;
    end
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      row_r   <= q_data.row;
      col_r   <= q_data.col;
      glyph_r <= glyph;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, glyph_r, col_r, row_r};

endmodule

### src/marching_squares_glyph.sv
// ============================================================================
// marching_squares_glyph
// Streaming marching-squares glyph generator. Grey pixels enter in raster
// order with a frame-start flag in in_tuser; every pixel past the first row
// and first column closes a 2x2 cell, whose corners are thresholded against
// level (top-left bit 3, top-right bit 2, bottom-right bit 1, bottom-left
// bit 0) and expanded into a 3x3 glyph of on_level and off_level values.
// One pixel is accepted per clock while the cell queue has room, set by the
// single read-and-write port of the previous-row line store; a cell result
// passes through the stage 1 register, the two-entry queue and the output
// register. Cells in the first row or first column give no result, and rows
// past MAX_HEIGHT are dropped until the next frame start.
// Configuration writes are accepted at any time but must be issued only
// while no pixel is in flight.
// ============================================================================
module marching_squares_glyph #(
  parameter int unsigned MAX_WIDTH  = mgs_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mgs_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mgs_pkg::PIX_W-1:0]         in_tdata,   // [7:0] pixel
  input  logic                              in_tuser,   // [0] frame_start
  // cell stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] cell_row, [19:10] cell_col, then g00 g01 g02 g10 g11 g12 g20 g21 g22
  // at 8 bits each from bit 20 up, zero fill above bit 91
  output logic [mgs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mgs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mgs_pkg::*;

  logic [IWIDTH_W-1:0] image_width_r;
  logic [PIX_W-1:0]    level_r;
  logic [PIX_W-1:0]    off_level_r;
  logic [PIX_W-1:0]    on_level_r;

  logic                fq_valid;
  logic                fq_ready;
  mgs_cell_t           fq_data;
  logic                qb_valid;
  logic                qb_ready;
  mgs_cell_t           qb_data;

  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r <= RST_IMAGE_WIDTH;
      level_r       <= RST_LEVEL;
      off_level_r   <= RST_OFF_LEVEL;
      on_level_r    <= RST_ON_LEVEL;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: image_width_r <= cfg_data[IWIDTH_W-1:0];
        REG_LEVEL:       level_r       <= cfg_data[PIX_W-1:0];
        REG_OFF_LEVEL:   off_level_r   <= cfg_data[PIX_W-1:0];
        REG_ON_LEVEL:    on_level_r    <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  // intake and classification
  mgs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_pixel    (in_tdata),
    .in_start    (in_tuser),
    .image_width (image_width_r),
    .level       (level_r),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .q_data      (fq_data)
  );

  // decoupling queue
  mgs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  // glyph output
  mgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_data     (qb_data),
    .off_level  (off_level_r),
    .on_level   (on_level_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### dv/tb_marching_squares_glyph.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_marching_squares_glyph
// Self-checking bench for the marching-squares glyph generator. A short
// table of directed pixels and register writes is followed by random frames
// of random width, level and glyph values. One frame is 1024 wide. A
// behavioral predictor in the bench computes the cell, if any, for every
// accepted pixel. Each cell transaction on the output is checked field by field
// against the oldest predicted cell, under random source gaps and sink
// back-pressure.
// ============================================================================
module tb_marching_squares_glyph;
  import mgs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned RANDOM_PIXELS = 1450;
  localparam int unsigned PACE_A_END    = 150;
  localparam int unsigned PACE_B_END    = 300;
  localparam int unsigned WIDE_AT       = 300;
  localparam int unsigned WIDE_PIXELS   = DEF_MAX_WIDTH + 40;
  localparam int unsigned MAX_PRINTS    = 200;
  localparam int unsigned FIELD_N       = 2 + GLYPH_N + 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(4);

  typedef logic [OUT_DATA_W-1:0] cell_word_t;
  typedef enum logic [1:0] {PX_UNIFORM, PX_NEAR_LEVEL, PX_CORNERS} px_style_t;

  // one row of the directed table
  typedef struct packed {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      px;
    bit                    start;
    bit                    typed;
    cell_word_t            want;
  } step_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [PIX_W-1:0]        in_tdata   = '0;
  logic                    in_tuser   = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  cell_word_t              out_tdata;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;

  // predictor state and its copy of the registers
  logic [PIX_W-1:0]        prev_row [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]        left_px    = '0;
  logic [PIX_W-1:0]        upleft_px  = '0;
  int unsigned             col_pos    = 0;
  int unsigned             row_pos    = 0;
  logic [IWIDTH_W-1:0]     width_reg  = RST_IMAGE_WIDTH;
  logic [PIX_W-1:0]        level_reg  = RST_LEVEL;
  logic [PIX_W-1:0]        off_reg    = RST_OFF_LEVEL;
  logic [PIX_W-1:0]        on_reg     = RST_ON_LEVEL;

  cell_word_t              cells_due [$];
  step_t                   steps [$];
  cell_word_t              due_cell;
  int unsigned             mismatches = 0;
  int unsigned             cycle_cnt  = 0;
  int unsigned             in_idle_pct  = 0;
  int unsigned             out_idle_pct = 0;
  int unsigned             hold_asks  = 0;
  int unsigned             hold_seen  = 0;
  int unsigned             hold_left  = 0;
  bit                      force_start = 1'b0;

  marching_squares_glyph i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  // contour positions per corner case, bit (3*row + col)
  function automatic logic [GLYPH_N-1:0] contour_of(logic [CODE_W-1:0] code);
    case (code)
      4'd1, 4'd14: return 9'h0C8;
      4'd2, 4'd13: return 9'h1A0;
      4'd3, 4'd12: return 9'h038;
      4'd4, 4'd11: return 9'h026;
      4'd5:        return 9'h0EE;
      4'd6, 4'd9:  return 9'h092;
      4'd7, 4'd8:  return 9'h00B;
      4'd10:       return 9'h1AB;
      default:     return 9'h000;
    endcase
  endfunction

  function automatic int unsigned eff_width(logic [IWIDTH_W-1:0] w);
    if (w < 2) return 2;
    if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
    return w;
  endfunction

  // field k of a cell word: row, col, nine glyph values, then the zero fill
  function automatic logic [CELL_W-1:0] field_slice(cell_word_t v, int k);
    if (k == 0) return v[CELL_W-1:0];
    if (k == 1) return v[2*CELL_W-1:CELL_W];
    if (k == FIELD_N - 1) return CELL_W'(v[OUT_DATA_W-1:OUT_BITS]);
    return CELL_W'(v[2*CELL_W + PIX_W*(k-2) +: PIX_W]);
  endfunction

  function automatic string field_name(int k);
    case (k)
      0: return "cell_row";
      1: return "cell_col";
      2: return "g00";
      3: return "g01";
      4: return "g02";
      5: return "g10";
      6: return "g11";
      7: return "g12";
      8: return "g20";
      9: return "g21";
      10: return "g22";
      default: return "zero fill";
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] make_pixel(px_style_t style);
    int v;
    case (style)
      PX_NEAR_LEVEL: begin
        v = int'(level_reg) + int'($urandom_range(3, 0)) - 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return PIX_W'(v);
      end
      PX_CORNERS: begin
        case ($urandom_range(3, 0))
          0: return '0;
          1: return '1;
          2: return level_reg;
          default: return level_reg - 1'b1;
        endcase
      end
      default: return PIX_W'($urandom_range(255, 0));
    endcase
  endfunction

  // byte register value, upper data bits random so the masking is exercised
  function automatic logic [CFG_DATA_W-1:0] pick_byte();
    case ($urandom_range(4, 0))
      0: return '0;
      1: return CFG_DATA_W'(255);
      2: return CFG_DATA_W'($urandom_range(2047, 0));
      default: return CFG_DATA_W'($urandom_range(255, 0));
    endcase
  endfunction

  // next cell of the stream, if the pixel closes one
  task automatic classify_pixel(input logic [PIX_W-1:0] px, input bit start,
                                output bit made, output cell_word_t pred);
    int unsigned w;
    int unsigned col;
    logic [PIX_W-1:0] up;
    logic [CODE_W-1:0] code;
    logic [GLYPH_N-1:0] m;
    made = 1'b0;
    pred = '0;
    w = eff_width(width_reg);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // rows past the height limit are dropped
    if (row_pos < DEF_MAX_HEIGHT) begin
      col = (col_pos >= DEF_MAX_WIDTH) ? 0 : col_pos;
      up = prev_row[col];
      if (row_pos >= 1 && col >= 1) begin
        code = {upleft_px >= level_reg, up >= level_reg, px >= level_reg,
                left_px >= level_reg};
        m = contour_of(code);
        pred[CELL_W-1:0] = CELL_W'(row_pos - 1);
        pred[2*CELL_W-1:CELL_W] = CELL_W'(col - 1);
        for (int k = 0; k < GLYPH_N; k++)
          pred[2*CELL_W + PIX_W*k +: PIX_W] = m[k] ? on_reg : off_reg;
        made = 1'b1;
      end
      upleft_px = up;
      left_px = px;
      prev_row[col] = px;
      if (col + 1 >= w) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos = col + 1;
      end
    end
  endtask

  // one register write transaction
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int unsigned old_w;
    old_w = eff_width(width_reg);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH: width_reg = data;
      REG_LEVEL:       level_reg = data[PIX_W-1:0];
      REG_OFF_LEVEL:   off_reg   = data[PIX_W-1:0];
      REG_ON_LEVEL:    on_reg    = data[PIX_W-1:0];
      default: ;
    endcase
    // a wider row would read unwritten line store entries, so restart
    if (eff_width(width_reg) > old_w) force_start = 1'b1;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // one pixel transaction, with random source gaps
  task automatic send_pixel(input logic [PIX_W-1:0] px, input bit start, input bit typed,
                            input cell_word_t want);
    bit made;
    bit first;
    cell_word_t pred;
    first = start | force_start;
    force_start = 1'b0;
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = px;
    in_tuser  = first;
    do @(posedge clk); while (!in_tready);
    classify_pixel(px, first, made, pred);
    if (typed) cells_due.push_back(want);
    else if (made) cells_due.push_back(pred);
    @(negedge clk);
  endtask

  // wait until every predicted cell has come out and the pipe is empty
  task automatic drain();
    in_tvalid = 1'b0;
    while (cells_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_frame(input int unsigned total, input px_style_t style, input bit fresh);
    for (int unsigned i = 0; i < total; i++)
      send_pixel(make_pixel(style), (i == 0 && fresh) || $urandom_range(99, 0) == 0, 1'b0, '0);
  endtask

  // random register changes between frames
  task automatic retune();
    int unsigned r;
    drain();
    r = $urandom_range(99, 0);
    if ($urandom_range(1, 0) == 1) begin
      if (r < 8) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(1, 0)));
      else if (r < 90) write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(12, 2)));
      else write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(40, 13)));
    end
    if ($urandom_range(1, 0) == 1) write_reg(REG_LEVEL, pick_byte());
    if ($urandom_range(9, 0) < 3) write_reg(REG_OFF_LEVEL, pick_byte());
    if ($urandom_range(9, 0) < 3) write_reg(REG_ON_LEVEL, pick_byte());
    if ($urandom_range(9, 0) == 0)
      write_reg(CFG_IDX_W'($urandom_range(255, 4)), CFG_DATA_W'($urandom_range(2047, 0)));
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    steps.push_back('{1'b1, idx, data, '0, 1'b0, 1'b0, '0});
  endtask

  task automatic add_px(input logic [PIX_W-1:0] px, input bit start);
    steps.push_back('{1'b0, '0, '0, px, start, 1'b0, '0});
  endtask

  task automatic add_px_want(input logic [PIX_W-1:0] px, input bit start,
                             input logic [CELL_W-1:0] row, input logic [CELL_W-1:0] col,
                             input logic [GLYPH_N*PIX_W-1:0] glyph);
    steps.push_back('{1'b0, '0, '0, px, start, 1'b1, cell_word_t'({glyph, col, row})});
  endtask

  // sink back-pressure, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      out_tready = $urandom_range(99, 0) >= out_idle_pct;
    end
  end

  // cell transaction checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cells_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS)
          $display("%0t: cell with none expected, expected none, actual %h", $time, out_tdata);
      end else begin
        due_cell = cells_due.pop_front();
        for (int k = 0; k < FIELD_N; k++) begin
          if (field_slice(out_tdata, k) !== field_slice(due_cell, k)) begin
            mismatches++;
            if (mismatches <= MAX_PRINTS)
              $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field_name(k),
                       field_slice(due_cell, k), field_slice(out_tdata, k));
          end
        end
      end
    end
  end

  // run time limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_marching_squares_glyph NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned regular;
    int unsigned w;
    int unsigned total;
    bit wide_done;
    bit held;
    regular = 0;
    wide_done = 1'b0;
    held = 1'b0;

    // directed table, reset levels first, no frame start after reset
    add_cfg(REG_IMAGE_WIDTH, 11'd0);
    add_px(8'd0, 1'b0);
    add_px(8'd255, 1'b0);
    add_px(8'd0, 1'b0);
    add_px_want(8'd255, 1'b0, 10'd0, 10'd0, 72'h00ff0000ff0000ff00);
    add_px(8'd128, 1'b0);
    add_px(8'd127, 1'b0);
    // all corners set gives an empty glyph
    add_px(8'd255, 1'b1);
    add_px(8'd255, 1'b0);
    add_px(8'd255, 1'b0);
    add_px_want(8'd255, 1'b0, 10'd0, 10'd0, 72'h0);
    // level zero, inverted glyph levels, upper data bits dropped
    add_cfg(REG_LEVEL, 11'h700);
    add_cfg(REG_OFF_LEVEL, 11'h7ff);
    add_cfg(REG_ON_LEVEL, 11'd0);
    add_cfg(REG_UNMAPPED, 11'h7ff);
    add_px(8'd0, 1'b0);
    add_px_want(8'd0, 1'b0, 10'd1, 10'd0, {GLYPH_N{8'hff}});
    // top level, a corner counts only at 255
    add_cfg(REG_LEVEL, 11'd255);
    add_cfg(REG_OFF_LEVEL, 11'd0);
    add_cfg(REG_ON_LEVEL, 11'd255);
    add_px(8'd255, 1'b1);
    add_px(8'd254, 1'b0);
    add_px(8'd254, 1'b0);
    add_px(8'd255, 1'b0);
    add_cfg(REG_LEVEL, 11'd128);

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    in_idle_pct  = 18;
    out_idle_pct = 58;

    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        drain();
        write_reg(steps[i].idx, steps[i].data);
      end else begin
        send_pixel(steps[i].px, steps[i].start, steps[i].typed, steps[i].want);
      end
    end

    // random frames
    while (regular < RANDOM_PIXELS) begin
      if (regular < PACE_A_END) begin
        in_idle_pct  = 18;
        out_idle_pct = 58;
      end else if (regular < PACE_B_END) begin
        in_idle_pct  = 58;
        out_idle_pct = 18;
      end else begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      retune();
      if (!wide_done && regular >= WIDE_AT) begin
        // widest row, register value above the limit
        wide_done = 1'b1;
        write_reg(REG_IMAGE_WIDTH, 11'h7ff);
        run_frame(WIDE_PIXELS, PX_UNIFORM, 1'b1);
        regular += WIDE_PIXELS;
      end else begin
        w = eff_width(width_reg);
        total = $urandom_range(6, 2) * w;
        case ($urandom_range(3, 0))
          0: total += $urandom_range(w - 1, 0);
          1: total -= $urandom_range(w - 1, 0);
          default: ;
        endcase
        if (total > RANDOM_PIXELS - regular) total = RANDOM_PIXELS - regular;
        // long sink stall while pixels keep coming
        if (!held && regular >= PACE_B_END) begin
          held = 1'b1;
          hold_asks++;
        end
        run_frame(total, px_style_t'($urandom_range(2, 0)), $urandom_range(3, 0) != 0);
        regular += total;
      end
    end

    drain();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_marching_squares_glyph OK");
    end else begin
      $display("tb_marching_squares_glyph NOT OK");
    end
    $finish;
  end

endmodule
